// ----- rtl/bbc_pkg.sv -----
// ----------------------------------------------------------------------------
// Block buffer cache package
// Transaction payload types, sequencer codes and register map constants that
// the controller, its tag store and its LRU chain share.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bbc_pkg;

   localparam int DEV_FIELD_BITS = 8;
   localparam int BLK_FIELD_BITS = 32;
   localparam int BUF_FIELD_BITS = 6;
   localparam int PIN_BITS       = 8;

   localparam int          CSR_ADDR_BITS       = 3;
   localparam int          CSR_DATA_BITS       = 32;
   localparam logic [0:0]  CSR_NO_DEVICE_INDEX = 1'b0;

   typedef enum logic {
      REQ_GET = 1'b0,
      REQ_PUT = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic                      req_type;
      logic [DEV_FIELD_BITS-1:0] device;
      logic [BLK_FIELD_BITS-1:0] block_number;
      logic [BUF_FIELD_BITS-1:0] buffer_index;
      logic                      mark_dirty;
      logic                      write_immediately;
   } req_item_type;

   typedef struct packed {
      logic [BUF_FIELD_BITS-1:0] result_buffer;
      logic                      hit;
      logic                      no_free_buffer;
      logic                      read_request;
      logic                      flush_request;
      logic [DEV_FIELD_BITS-1:0] flush_device;
      logic                      write_request;
   } rsp_item_type;

   typedef enum logic {
      LRU_REMOVE = 1'b0,
      LRU_APPEND = 1'b1
   } lru_op_type;

   typedef struct packed {
      logic       start;
      lru_op_type op;
      logic       clear;
   } lru_cmd_type;

   typedef struct packed {
      logic idle;
      logic empty;
   } lru_status_type;

   typedef struct packed {
      logic dev_eq;
      logic tag_eq;
   } tag_cmp_type;

endpackage

`default_nettype wire

// ----- rtl/bbc_tag_unit.sv -----
// ----------------------------------------------------------------------------
// Block buffer cache tag store
// Per-buffer tag, pin count and dirty mark in one memory with a registered
// read port, and the tag comparator shared by the lookup and flush sweeps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bbc_tag_unit #(
   parameter int NUM_BUFFERS = 64,
   parameter int DEVICE_BITS = 8,
   parameter int BLOCK_BITS  = 32
) (
   input  wire                               clock,
   input  wire                               wr_en,
   input  wire [$clog2(NUM_BUFFERS)-1:0]     wr_addr,
   input  wire [DEVICE_BITS-1:0]             wr_dev,
   input  wire [BLOCK_BITS-1:0]              wr_blk,
   input  wire [bbc_pkg::PIN_BITS-1:0]       wr_pin,
   input  wire                               wr_dirty,
   input  wire [$clog2(NUM_BUFFERS)-1:0]     rd_addr,
   input  wire [DEVICE_BITS-1:0]             key_dev,
   input  wire [BLOCK_BITS-1:0]              key_blk,
   output logic [DEVICE_BITS-1:0]            rd_dev,
   output logic [BLOCK_BITS-1:0]             rd_blk,
   output logic [bbc_pkg::PIN_BITS-1:0]      rd_pin,
   output logic                              rd_dirty,
   output bbc_pkg::tag_cmp_type              cmp
);
   import bbc_pkg::*;

   localparam int WORD_BITS = DEVICE_BITS + BLOCK_BITS + PIN_BITS + 1;

   logic [WORD_BITS-1:0] mem [NUM_BUFFERS];
   logic [WORD_BITS-1:0] rd_word_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_dev, wr_blk, wr_pin, wr_dirty};
      end
      rd_word_ff <= mem[rd_addr];
   end

   assign {rd_dev, rd_blk, rd_pin, rd_dirty} = rd_word_ff;

   assign cmp.dev_eq = (rd_dev == key_dev);
   assign cmp.tag_eq = cmp.dev_eq && (rd_blk == key_blk);

endmodule

`default_nettype wire

// ----- rtl/bbc_lru_unit.sv -----
// ----------------------------------------------------------------------------
// Block buffer cache LRU chain
// Doubly linked replacement chain held in next and prev link memories, with
// front and rear pointers; unlinks, appends or clears the links of one buffer per command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bbc_lru_unit #(
   parameter int NUM_BUFFERS = 64
) (
   input  wire                               clock,
   input  wire                               reset,
   input  bbc_pkg::lru_cmd_type              cmd,
   input  wire [$clog2(NUM_BUFFERS)-1:0]     cmd_buf,
   output bbc_pkg::lru_status_type           status,
   output logic [$clog2(NUM_BUFFERS)-1:0]    front_buf
);
   import bbc_pkg::*;

   localparam int IW = $clog2(NUM_BUFFERS);
   localparam int LW = $clog2(NUM_BUFFERS + 1);
   localparam logic [LW-1:0] NIL = LW'(NUM_BUFFERS);

   typedef enum logic [2:0] {
      L_IDLE   = 3'b001,
      L_REMOVE = 3'b010,
      L_APPEND = 3'b100
   } lru_state_type;

   logic [LW-1:0] next_mem [NUM_BUFFERS];
   logic [LW-1:0] prev_mem [NUM_BUFFERS];

   lru_state_type state_ff, state_in;
   logic [LW-1:0] front_ff, front_in;
   logic [LW-1:0] rear_ff, rear_in;
   logic [IW-1:0] buf_ff, buf_in;
   logic [LW-1:0] nrd_ff, prd_ff;

   logic          next_we, prev_we;
   logic [IW-1:0] next_wa, prev_wa;
   logic [LW-1:0] next_wd, prev_wd;

   always_comb begin
      state_in = state_ff;
      front_in = front_ff;
      rear_in  = rear_ff;
      buf_in   = buf_ff;
      next_we  = 1'b0;
      prev_we  = 1'b0;
      next_wa  = cmd_buf;
      prev_wa  = cmd_buf;
      next_wd  = NIL;
      prev_wd  = NIL;
      case (state_ff)
         L_IDLE: begin
            buf_in = cmd_buf;
            if (cmd.clear) begin
               next_we = 1'b1;
               prev_we = 1'b1;
               next_wd = LW'(cmd_buf) + LW'(1);
               prev_wd = (cmd_buf == '0) ? NIL : LW'(cmd_buf) - LW'(1);
            end else if (cmd.start && cmd.op == LRU_APPEND) begin
               next_we  = 1'b1;
               prev_we  = 1'b1;
               next_wd  = NIL;
               prev_wd  = rear_ff;
               state_in = L_APPEND;
            end else if (cmd.start) begin
               state_in = L_REMOVE;
            end
         end
         L_REMOVE: begin
            if (prd_ff != NIL) begin
               next_we = 1'b1;
               next_wa = prd_ff[IW-1:0];
               next_wd = nrd_ff;
            end else begin
               front_in = nrd_ff;
            end
            if (nrd_ff != NIL) begin
               prev_we = 1'b1;
               prev_wa = nrd_ff[IW-1:0];
               prev_wd = prd_ff;
            end else begin
               rear_in = prd_ff;
            end
            state_in = L_IDLE;
         end
         L_APPEND: begin
            if (rear_ff != NIL) begin
               next_we = 1'b1;
               next_wa = rear_ff[IW-1:0];
               next_wd = LW'(buf_ff);
            end else begin
               front_in = LW'(buf_ff);
            end
            rear_in  = LW'(buf_ff);
            state_in = L_IDLE;
         end
         default: begin
            state_in = L_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         front_ff <= '0;
         rear_ff  <= LW'(NUM_BUFFERS - 1);
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         rear_ff  <= rear_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      nrd_ff <= next_mem[cmd_buf];
      prd_ff <= prev_mem[cmd_buf];
      if (next_we) begin
         next_mem[next_wa] <= next_wd;
      end
      if (prev_we) begin
         prev_mem[prev_wa] <= prev_wd;
      end
   end

   assign status.idle  = (state_ff == L_IDLE);
   assign status.empty = (front_ff == NIL);
   assign front_buf    = front_ff[IW-1:0];

endmodule

`default_nettype wire

// ----- rtl/block_buffer_cache_lru.sv -----
// ----------------------------------------------------------------------------
// Block buffer cache with LRU replacement
// Tag and replacement controller for a pool of block buffers with pin counts.
//
// A get transaction names a device and a block; the controller sweeps the
// tag store one buffer per cycle through a shared comparator. A hit pins the
// buffer; a miss takes the front of the LRU chain, requests a flush when the
// victim is dirty (a second sweep cleans every buffer of that device), and
// retags it. A put transaction unpins a buffer and, at count zero, appends it
// to the LRU rear and may request an immediate write.
// One transaction is processed at a time and req_ready is low meanwhile.
// A get with the no-device code skips the lookup.
// The result sits in an output register, so a new request is accepted while
// it waits; a stalled receiver holds the next result back in its final step.
// After reset a clearing pass over all NUM_BUFFERS entries initialises the
// tag and link memories before the first request is accepted; register
// writes are taken throughout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module block_buffer_cache_lru #(
   parameter int NUM_BUFFERS = 64,
   parameter int BLOCK_BITS  = 32,
   parameter int DEVICE_BITS = 8
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_ready,
   input  bbc_pkg::req_item_type                 req_data,
   output logic                                  rsp_valid,
   input  wire                                   rsp_ready,
   output bbc_pkg::rsp_item_type                 rsp_data,
   input  wire                                   psel,
   input  wire                                   penable,
   input  wire                                   pwrite,
   input  wire [bbc_pkg::CSR_ADDR_BITS-1:0]      paddr,
   input  wire [bbc_pkg::CSR_DATA_BITS-1:0]      pwdata,
   output logic [bbc_pkg::CSR_DATA_BITS-1:0]     prdata,
   output logic                                  pready
);
   import bbc_pkg::*;

   localparam int IW = $clog2(NUM_BUFFERS);
   localparam int LW = $clog2(NUM_BUFFERS + 1);
   localparam logic [IW-1:0] LAST = IW'(NUM_BUFFERS - 1);

   typedef enum logic [10:0] {
      S_CLEAR  = 11'h001,
      S_IDLE   = 11'h002,
      S_SCAN   = 11'h004,
      S_VICTIM = 11'h008,
      S_VREAD  = 11'h010,
      S_VCHK   = 11'h020,
      S_FLUSH  = 11'h040,
      S_RETAG  = 11'h080,
      S_PREAD  = 11'h100,
      S_PCHK   = 11'h200,
      S_RESP   = 11'h400
   } state_type;

   state_type            state_ff, state_in;
   logic [LW-1:0]        cnt_ff, cnt_in;
   logic                 pend_ff, pend_in;
   logic [DEV_FIELD_BITS-1:0] nodev_ff, nodev_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [IW-1:0]        chk_ff, chk_in;
   logic [IW-1:0]        b_ff, b_in;
   logic [DEVICE_BITS-1:0] dev_ff, dev_in;
   logic [DEVICE_BITS-1:0] fdev_ff, fdev_in;
   logic [BLOCK_BITS-1:0]  blk_ff, blk_in;
   logic                 mark_ff, mark_in;
   logic                 wimm_ff, wimm_in;
   rsp_item_type         res_ff, res_in;
   rsp_item_type         rsp_data_ff, rsp_data_in;

   logic [DEVICE_BITS-1:0] nd;

   logic                   tag_we;
   logic [IW-1:0]          tag_wa;
   logic [DEVICE_BITS-1:0] tag_wdev;
   logic [BLOCK_BITS-1:0]  tag_wblk;
   logic [PIN_BITS-1:0]    tag_wpin;
   logic                   tag_wdirty;
   logic [IW-1:0]          tag_ra;
   logic [DEVICE_BITS-1:0] key_dev;
   logic [DEVICE_BITS-1:0] rd_dev;
   logic [BLOCK_BITS-1:0]  rd_blk;
   logic [PIN_BITS-1:0]    rd_pin;
   logic                   rd_dirty;
   tag_cmp_type            cmp;

   lru_cmd_type            lru_cmd;
   logic [IW-1:0]          lru_buf;
   lru_status_type         lru_status;
   logic [IW-1:0]          front_buf;

   logic                   csr_write;

   assign nd        = DEVICE_BITS'(nodev_ff);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      nodev_in = nodev_ff;
      if (csr_write && paddr[CSR_ADDR_BITS-1] == CSR_NO_DEVICE_INDEX) begin
         nodev_in = pwdata[DEV_FIELD_BITS-1:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[CSR_ADDR_BITS-1] == CSR_NO_DEVICE_INDEX) ?
                   CSR_DATA_BITS'(nodev_ff) : '0;

   always_comb begin
      logic [PIN_BITS-1:0] pin_dec;
      logic                dirty_new;
      logic                wreq;

      pin_dec     = rd_pin - PIN_BITS'(1);
      dirty_new   = rd_dirty | mark_ff;
      wreq        = wimm_ff && dirty_new && (rd_dev != nd);

      state_in    = state_ff;
      cnt_in      = cnt_ff;
      pend_in     = pend_ff;
      chk_in      = chk_ff;
      b_in        = b_ff;
      dev_in      = dev_ff;
      fdev_in     = fdev_ff;
      blk_in      = blk_ff;
      mark_in     = mark_ff;
      wimm_in     = wimm_ff;
      res_in      = res_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      tag_we      = 1'b0;
      tag_wa      = chk_ff;
      tag_wdev    = rd_dev;
      tag_wblk    = rd_blk;
      tag_wpin    = rd_pin;
      tag_wdirty  = rd_dirty;
      tag_ra      = b_ff;
      key_dev     = dev_ff;
      lru_cmd     = '0;
      lru_buf     = b_ff;

      case (state_ff)
         S_CLEAR: begin
            tag_we        = 1'b1;
            tag_wa        = cnt_ff[IW-1:0];
            tag_wdev      = '0;
            tag_wblk      = '0;
            tag_wpin      = '0;
            tag_wdirty    = 1'b0;
            lru_cmd.clear = 1'b1;
            lru_buf       = cnt_ff[IW-1:0];
            cnt_in        = cnt_ff + LW'(1);
            if (cnt_ff[IW-1:0] == LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               dev_in  = DEVICE_BITS'(req_data.device);
               blk_in  = BLOCK_BITS'(req_data.block_number);
               mark_in = req_data.mark_dirty;
               wimm_in = req_data.write_immediately;
               b_in    = IW'(req_data.buffer_index);
               cnt_in  = '0;
               pend_in = 1'b0;
               res_in  = '0;
               if (req_data.req_type == REQ_PUT) begin
                  res_in.result_buffer = req_data.buffer_index;
                  if (int'(req_data.buffer_index) < NUM_BUFFERS) begin
                     state_in = S_PREAD;
                  end else begin
                     state_in = S_RESP;
                  end
               end else if (DEVICE_BITS'(req_data.device) != nd) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_VICTIM;
               end
            end
         end
         S_SCAN: begin
            tag_ra = cnt_ff[IW-1:0];
            if (pend_ff && cmp.tag_eq) begin
               tag_we   = 1'b1;
               tag_wpin = (rd_pin == '1) ? rd_pin : rd_pin + PIN_BITS'(1);
               if (rd_pin == '0) begin
                  lru_cmd.start = 1'b1;
                  lru_cmd.op    = LRU_REMOVE;
                  lru_buf       = chk_ff;
               end
               res_in.hit           = 1'b1;
               res_in.result_buffer = BUF_FIELD_BITS'(chk_ff);
               state_in             = S_RESP;
            end else if (pend_ff && chk_ff == LAST) begin
               state_in = S_VICTIM;
            end else begin
               chk_in  = cnt_ff[IW-1:0];
               pend_in = 1'b1;
               cnt_in  = cnt_ff + LW'(1);
            end
         end
         S_VICTIM: begin
            if (lru_status.empty) begin
               res_in.no_free_buffer = 1'b1;
               state_in              = S_RESP;
            end else begin
               b_in          = front_buf;
               lru_cmd.start = 1'b1;
               lru_cmd.op    = LRU_REMOVE;
               lru_buf       = front_buf;
               state_in      = S_VREAD;
            end
         end
         S_VREAD: begin
            state_in = S_VCHK;
         end
         S_VCHK: begin
            cnt_in  = '0;
            pend_in = 1'b0;
            if (rd_dev != nd && rd_dirty) begin
               res_in.flush_request = 1'b1;
               res_in.flush_device  = DEV_FIELD_BITS'(rd_dev);
               fdev_in              = rd_dev;
               state_in             = S_FLUSH;
            end else begin
               state_in = S_RETAG;
            end
         end
         S_FLUSH: begin
            tag_ra  = cnt_ff[IW-1:0];
            key_dev = fdev_ff;
            if (pend_ff && cmp.dev_eq) begin
               tag_we     = 1'b1;
               tag_wdirty = 1'b0;
            end
            if (pend_ff && chk_ff == LAST) begin
               state_in = S_RETAG;
            end else begin
               chk_in  = cnt_ff[IW-1:0];
               pend_in = 1'b1;
               cnt_in  = cnt_ff + LW'(1);
            end
         end
         S_RETAG: begin
            tag_we               = 1'b1;
            tag_wa               = b_ff;
            tag_wdev             = dev_ff;
            tag_wblk             = blk_ff;
            tag_wpin             = PIN_BITS'(1);
            tag_wdirty           = 1'b0;
            res_in.result_buffer = BUF_FIELD_BITS'(b_ff);
            res_in.read_request  = (dev_ff != nd);
            state_in             = S_RESP;
         end
         S_PREAD: begin
            state_in = S_PCHK;
         end
         S_PCHK: begin
            if (rd_pin != '0) begin
               tag_we     = 1'b1;
               tag_wa     = b_ff;
               tag_wpin   = pin_dec;
               tag_wdirty = dirty_new;
               if (pin_dec == '0) begin
                  lru_cmd.start = 1'b1;
                  lru_cmd.op    = LRU_APPEND;
                  if (wreq) begin
                     res_in.write_request = 1'b1;
                     tag_wdirty           = 1'b0;
                  end
               end
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (lru_status.idle && (!rsp_valid_ff || rsp_ready)) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         nodev_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         nodev_ff     <= nodev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_ff      <= chk_in;
      b_ff        <= b_in;
      dev_ff      <= dev_in;
      fdev_ff     <= fdev_in;
      blk_ff      <= blk_in;
      mark_ff     <= mark_in;
      wimm_ff     <= wimm_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   bbc_tag_unit #(
      .NUM_BUFFERS (NUM_BUFFERS),
      .DEVICE_BITS (DEVICE_BITS),
      .BLOCK_BITS  (BLOCK_BITS)
   ) u_tag (
      .clock    (clock),
      .wr_en    (tag_we),
      .wr_addr  (tag_wa),
      .wr_dev   (tag_wdev),
      .wr_blk   (tag_wblk),
      .wr_pin   (tag_wpin),
      .wr_dirty (tag_wdirty),
      .rd_addr  (tag_ra),
      .key_dev  (key_dev),
      .key_blk  (blk_ff),
      .rd_dev   (rd_dev),
      .rd_blk   (rd_blk),
      .rd_pin   (rd_pin),
      .rd_dirty (rd_dirty),
      .cmp      (cmp)
   );

   bbc_lru_unit #(
      .NUM_BUFFERS (NUM_BUFFERS)
   ) u_lru (
      .clock     (clock),
      .reset     (reset),
      .cmd       (lru_cmd),
      .cmd_buf   (lru_buf),
      .status    (lru_status),
      .front_buf (front_buf)
   );

endmodule

`default_nettype wire

// ----- rtl/bbc_checker.sv -----
// ----------------------------------------------------------------------------
// Block buffer cache port checker
// Concurrent checks on the request and result channels of the controller,
// attached to the top level by a bind statement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bbc_checker (
   input wire                   clock,
   input wire                   reset,
   input wire                   req_valid,
   input wire                   req_ready,
   input wire                   rsp_valid,
   input wire                   rsp_ready,
   input bbc_pkg::rsp_item_type rsp_data
);
   import bbc_pkg::*;

   // A result that is not taken stays offered unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result transaction changed while stalled");

   // The controller works on one transaction at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a transaction was in progress");

   // A hit neither reads, flushes, writes nor reports an empty chain.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit |->
         !rsp_data.read_request && !rsp_data.flush_request &&
         !rsp_data.no_free_buffer && !rsp_data.write_request)
      else $error("hit result carries a miss or release indication");

   // With no free buffer nothing is granted and no transfer is requested.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.no_free_buffer |->
         rsp_data.result_buffer == '0 && !rsp_data.read_request &&
         !rsp_data.flush_request)
      else $error("no-free-buffer result grants a buffer or a transfer");

endmodule

bind block_buffer_cache_lru bbc_checker u_checker (.*);

`default_nettype wire

// ----- test/block_buffer_cache_lru_tb.sv -----
// ----------------------------------------------------------------------------
// Block buffer cache LRU controller testbench
// Drives get and put transactions through the request channel, changes the
// no-device code between phases over the APB port, and checks every result
// against a predictor of the tag store, pin counts and LRU chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class buffer_pool_model;
   localparam int NBUF = 64;
   localparam int NIL  = 64;

   bit [7:0]              no_dev;
   bit [7:0]              dev_tag [NBUF];
   bit [31:0]             blk_tag [NBUF];
   int unsigned           pins [NBUF];
   bit                    dirty [NBUF];
   int                    lru_nxt [NBUF];
   int                    lru_prv [NBUF];
   int                    lru_head;
   int                    lru_tail;
   bbc_pkg::rsp_item_type expected_q [$];
   int                    errors;

   function new();
      no_dev = 8'd0;
      for (int i = 0; i < NBUF; i++) begin
         dev_tag[i] = 8'd0;
         blk_tag[i] = 32'd0;
         pins[i]    = 0;
         dirty[i]   = 1'b0;
         lru_nxt[i] = i + 1;
         lru_prv[i] = (i == 0) ? NIL : i - 1;
      end
      lru_head = 0;
      lru_tail = NBUF - 1;
      errors   = 0;
   endfunction

   function void unlink(int b);
      int n;
      int p;
      n = lru_nxt[b];
      p = lru_prv[b];
      if (p < NBUF) lru_nxt[p] = n; else lru_head = n;
      if (n < NBUF) lru_prv[n] = p; else lru_tail = p;
      lru_nxt[b] = NIL;
      lru_prv[b] = NIL;
   endfunction

   function void note_request(bbc_pkg::req_item_type r);
      bbc_pkg::rsp_item_type e;
      int                    b;
      bit                    found;
      bit [7:0]              fd;
      e     = '0;
      b     = 0;
      found = 1'b0;
      if (r.req_type == bbc_pkg::REQ_GET) begin
         if (r.device != no_dev) begin
            for (int i = 0; i < NBUF; i++) begin
               if (!found && dev_tag[i] == r.device && blk_tag[i] == r.block_number) begin
                  found = 1'b1;
                  b     = i;
               end
            end
         end
         if (found) begin
            if (pins[b] == 0) unlink(b);
            if (pins[b] < 255) pins[b]++;
            e.result_buffer = b[5:0];
            e.hit           = 1'b1;
         end else if (lru_head >= NBUF) begin
            e.no_free_buffer = 1'b1;
         end else begin
            b = lru_head;
            unlink(b);
            if (dev_tag[b] != no_dev && dirty[b]) begin
               fd              = dev_tag[b];
               e.flush_request = 1'b1;
               e.flush_device  = fd;
               for (int i = 0; i < NBUF; i++) begin
                  if (dev_tag[i] == fd) dirty[i] = 1'b0;
               end
            end
            dirty[b]        = 1'b0;
            dev_tag[b]      = r.device;
            blk_tag[b]      = r.block_number;
            pins[b]         = 1;
            e.result_buffer = b[5:0];
            e.read_request  = (r.device != no_dev);
         end
      end else begin
         b               = int'(r.buffer_index);
         e.result_buffer = r.buffer_index;
         if (pins[b] != 0) begin
            if (r.mark_dirty) dirty[b] = 1'b1;
            pins[b]--;
            if (pins[b] == 0) begin
               lru_prv[b] = lru_tail;
               lru_nxt[b] = NIL;
               if (lru_tail < NBUF) lru_nxt[lru_tail] = b; else lru_head = b;
               lru_tail = b;
               if (r.write_immediately && dirty[b] && dev_tag[b] != no_dev) begin
                  e.write_request = 1'b1;
                  dirty[b]        = 1'b0;
               end
            end
         end
      end
      expected_q.push_back(e);
   endfunction

   task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   task compare_field(string name, logic [7:0] want, logic [7:0] seen);
      if (seen !== want) begin
         report_mismatch($sformatf("%s expected %0d, got %0d", name, want, seen));
      end
   endtask

   task check_response(bbc_pkg::rsp_item_type got);
      bbc_pkg::rsp_item_type e;
      if (expected_q.size() == 0) begin
         report_mismatch($sformatf("result for buffer %0d with no request waiting",
                                   got.result_buffer));
         return;
      end
      e = expected_q.pop_front();
      compare_field("result_buffer", 8'(e.result_buffer), 8'(got.result_buffer));
      compare_field("hit", 8'(e.hit), 8'(got.hit));
      compare_field("no_free_buffer", 8'(e.no_free_buffer), 8'(got.no_free_buffer));
      compare_field("read_request", 8'(e.read_request), 8'(got.read_request));
      compare_field("flush_request", 8'(e.flush_request), 8'(got.flush_request));
      compare_field("flush_device", e.flush_device, got.flush_device);
      compare_field("write_request", 8'(e.write_request), 8'(got.write_request));
   endtask

   function int pending();
      return expected_q.size();
   endfunction

   function int pick_pinned();
      int cands [$];
      foreach (pins[i]) begin
         if (pins[i] != 0) cands.push_back(i);
      end
      if (cands.size() == 0) return -1;
      return cands[$urandom_range(0, cands.size() - 1)];
   endfunction
endclass

module block_buffer_cache_lru_tb;
   import bbc_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_TAIL     = 2 * 64 + 20;
   localparam logic [CSR_ADDR_BITS-1:0] NO_DEVICE_ADDR =
      CSR_ADDR_BITS'(4 * int'(CSR_NO_DEVICE_INDEX));

   typedef enum int {
      ALWAYS_READY,
      COIN_FLIP,
      MOSTLY_STALLED
   } stall_mode_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   req_item_type             req_data;
   logic                     rsp_valid;
   logic                     rsp_ready;
   rsp_item_type             rsp_data;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   buffer_pool_model pool = new();
   int               burst_left;
   bit               sender_idle;
   stall_mode_type   stall_mode;
   int               stall_left;
   int               quiet_cycles;

   block_buffer_cache_lru dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 2));
         stall_left = $urandom_range(40, 400);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         ALWAYS_READY: rsp_ready <= 1'b1;
         COIN_FLIP:    rsp_ready <= 1'($urandom_range(0, 1));
         default:      rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) pool.check_response(rsp_data);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("block_buffer_cache_lru_tb: FAIL");
         $finish;
      end
   end

   function automatic req_item_type make_req(req_kind_type kind, logic [7:0] dev,
                                             logic [31:0] blk, logic [5:0] idx,
                                             logic md, logic wi);
      req_item_type r;
      r.req_type          = kind;
      r.device            = dev;
      r.block_number      = blk;
      r.buffer_index      = idx;
      r.mark_dirty        = md;
      r.write_immediately = wi;
      return r;
   endfunction

   // Every driving task is entered just after a rising edge and returns just
   // after one, so that valid is never lowered and raised in the same step.
   task issue(req_item_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_ready !== 1'b1);
      pool.note_request(item);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 15);
         if (sender_idle) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
      end
   endtask

   task wait_drained();
      req_valid <= 1'b0;
      while (pool.pending() != 0) @(posedge clock);
   endtask

   task program_no_device(logic [7:0] code);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= NO_DEVICE_ADDR;
      pwdata  <= CSR_DATA_BITS'(code);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      pool.no_dev = code;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== CSR_DATA_BITS'(code)) begin
         pool.report_mismatch($sformatf("no_device_code read back %0h, expected %0h",
                                        prdata, code));
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task release_all_pins();
      int b;
      b = pool.pick_pinned();
      while (b >= 0) begin
         issue(make_req(REQ_PUT, 8'($urandom_range(0, 255)), $urandom, 6'(b),
                        1'($urandom_range(0, 1)), 1'b1));
         b = pool.pick_pinned();
      end
   endtask

   task run_phase(int count, int get_pct);
      int          done;
      int          b;
      logic [7:0]  dev;
      logic [31:0] blk;
      done = 0;
      while (done < count) begin
         if ($urandom_range(1, 100) <= get_pct) begin
            case ($urandom_range(0, 9))
               0:       dev = pool.no_dev;
               1:       dev = 8'($urandom_range(0, 255));
               default: dev = 8'($urandom_range(0, 3));
            endcase
            case ($urandom_range(0, 9))
               0:       blk = $urandom;
               1:       blk = 32'hFFFF_FFFF;
               default: blk = $urandom_range(0, 23);
            endcase
            issue(make_req(REQ_GET, dev, blk, 6'($urandom_range(0, 63)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
            done++;
         end else begin
            b = pool.pick_pinned();
            if (b < 0 || $urandom_range(0, 6) == 0) b = $urandom_range(0, 63);
            if (pool.pins[b] != 0) done++;
            issue(make_req(REQ_PUT, 8'($urandom_range(0, 255)), $urandom, 6'(b),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
         end
         if ($urandom_range(0, 59) == 0) wait_drained();
      end
   endtask

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      rsp_ready   <= 1'b0;
      psel        <= 1'b0;
      penable     <= 1'b0;
      pwrite      <= 1'b0;
      paddr       <= '0;
      pwdata      <= '0;
      burst_left   = 0;
      sender_idle  = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      program_no_device(8'd0);

      // Short directed sequence covering the special cases that need few
      // transactions: no-device gets, hits on pinned and unpinned buffers,
      // immediate writes, ignored puts and several matching tags.
      issue(make_req(REQ_GET, 8'd0, 32'h1234_5678, 6'd0, 1'b1, 1'b1));
      issue(make_req(REQ_GET, 8'd1, 32'd0, 6'd63, 1'b0, 1'b0));
      issue(make_req(REQ_GET, 8'd1, 32'd0, 6'd0, 1'b0, 1'b0));
      issue(make_req(REQ_PUT, 8'd255, 32'hFFFF_FFFF, 6'd1, 1'b1, 1'b1));
      issue(make_req(REQ_PUT, 8'd0, 32'd0, 6'd1, 1'b0, 1'b1));
      issue(make_req(REQ_PUT, 8'd0, 32'd0, 6'd63, 1'b1, 1'b1));
      issue(make_req(REQ_PUT, 8'd0, 32'd0, 6'd0, 1'b1, 1'b1));
      issue(make_req(REQ_GET, 8'd255, 32'hFFFF_FFFF, 6'd0, 1'b0, 1'b0));
      issue(make_req(REQ_PUT, 8'd0, 32'd0, 6'd2, 1'b1, 1'b0));
      issue(make_req(REQ_GET, 8'd255, 32'hFFFF_FFFF, 6'd63, 1'b1, 1'b1));
      issue(make_req(REQ_PUT, 8'd0, 32'd0, 6'd2, 1'b0, 1'b0));
      issue(make_req(REQ_GET, 8'd1, 32'd0, 6'd0, 1'b0, 1'b0));
      issue(make_req(REQ_PUT, 8'd0, 32'd0, 6'd1, 1'b0, 1'b0));
      wait_drained();
      program_no_device(8'd7);
      issue(make_req(REQ_GET, 8'd0, 32'd0, 6'd0, 1'b0, 1'b0));
      issue(make_req(REQ_GET, 8'd7, 32'd5, 6'd0, 1'b0, 1'b0));
      issue(make_req(REQ_GET, 8'd0, 32'h1234_5678, 6'd0, 1'b0, 1'b0));
      issue(make_req(REQ_PUT, 8'd0, 32'd0, 6'd0, 1'b0, 1'b1));
      issue(make_req(REQ_PUT, 8'd0, 32'd0, 6'd3, 1'b1, 1'b0));
      issue(make_req(REQ_PUT, 8'd0, 32'd0, 6'd4, 1'b0, 1'b0));
      wait_drained();

      program_no_device(8'd255);
      run_phase(260, 55);
      wait_drained();
      program_no_device(8'd0);
      run_phase(260, 80);
      wait_drained();
      program_no_device(8'd2);
      sender_idle = 1'b0;
      run_phase(260, 35);
      wait_drained();

      // Pin one buffer well past the saturation point of its count, then
      // release every pin again.
      program_no_device(8'd128);
      sender_idle = 1'b1;
      release_all_pins();
      repeat (270) issue(make_req(REQ_GET, 8'd1, 32'd9, 6'($urandom_range(0, 63)),
                                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
      release_all_pins();
      wait_drained();

      program_no_device(8'd1);
      run_phase(260, 60);
      wait_drained();
      repeat (DRAIN_TAIL) @(posedge clock);

      if (pool.errors == 0 && pool.pending() == 0) begin
         $display("block_buffer_cache_lru_tb: PASS");
      end else begin
         $display("block_buffer_cache_lru_tb: FAIL");
      end
      $finish;
   end
endmodule

// ----- files.f -----
rtl/bbc_pkg.sv
rtl/bbc_tag_unit.sv
rtl/bbc_lru_unit.sv
rtl/block_buffer_cache_lru.sv
rtl/bbc_checker.sv
test/block_buffer_cache_lru_tb.sv
